/* hdl/assert_macros.svh */
// assertion macros used by multi_token_bucket_table
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/mtb_pkg.sv */
// shared types and codes for the token bucket table
// no dependencies
package mtb_pkg;

  // transaction kinds
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_OPEN   = 3'd1;
  localparam logic [2:0] KIND_FETCH  = 3'd2;
  localparam logic [2:0] KIND_RETURN = 3'd3;
  localparam logic [2:0] KIND_CLOSE  = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  // field widths fixed by the interface
  localparam int SLOT_BITS = 4;
  localparam int VAL_BITS  = 16;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_RD,
    S_TICK_WR,
    S_OPEN_SCAN,
    S_ACC_WR
  } mtb_state_e;

endpackage

/* hdl/mtb_bucket_ram.sv */
// bucket state memory: one word of count, rate and burst per slot
// synchronous write, registered read; no dependencies
module mtb_bucket_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mtb_bucket_alu.sv */
// count update for one bucket: saturating add or grant and subtract
// uses mtb_pkg for field widths
module mtb_bucket_alu #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         fetch_i,
  input  logic [COUNT_BITS-1:0]        count_i,
  input  logic [mtb_pkg::VAL_BITS-1:0] addend_i,
  input  logic [mtb_pkg::VAL_BITS-1:0] burst_i,
  output logic [COUNT_BITS-1:0]        count_o,
  output logic [mtb_pkg::VAL_BITS-1:0] grant_o,
  output logic                         empty_o
);
  import mtb_pkg::*;

  localparam int SUM_W = ((COUNT_BITS > VAL_BITS) ? COUNT_BITS : VAL_BITS) + 1;

  logic [SUM_W-1:0] count_w;
  logic [SUM_W-1:0] addend_w;
  logic [SUM_W-1:0] burst_w;
  logic [SUM_W-1:0] cmax_w;
  logic [SUM_W-1:0] cap_w;
  logic [SUM_W-1:0] sum_w;
  logic [SUM_W-1:0] clamp_w;
  logic [SUM_W-1:0] grant_w;
  logic [SUM_W-1:0] diff_w;

  // widen operands
  assign count_w  = SUM_W'(count_i);
  assign addend_w = SUM_W'(addend_i);
  assign burst_w  = SUM_W'(burst_i);
  assign cmax_w   = {{(SUM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  // saturating add, cap is the smaller of burst and the count range
  assign cap_w   = (burst_w < cmax_w) ? burst_w : cmax_w;
  assign sum_w   = count_w + addend_w;
  assign clamp_w = (sum_w < cap_w) ? sum_w : cap_w;

  // grant the smaller of request and count
  assign grant_w = (addend_w < count_w) ? addend_w : count_w;
  assign diff_w  = count_w - grant_w;

  assign count_o = fetch_i ? diff_w[COUNT_BITS-1:0] : clamp_w[COUNT_BITS-1:0];
  assign grant_o = grant_w[VAL_BITS-1:0];
  assign empty_o = (count_i == '0);

endmodule

/* hdl/multi_token_bucket_table.sv */
// top level of the token bucket table: controller, valid bits, result register
// uses mtb_pkg, mtb_bucket_ram, mtb_bucket_alu and assert_macros.svh
//
// A transaction is taken when start is high and busy is low; its single result
// shows on status_o, slot_out_o and granted_o for one cycle with done_o high,
// in the first cycle after the transaction completes (busy is low then), and
// must be taken then. Bucket state sits in a one-port-read, one-port-write
// memory with a registered read, so every fetch, return and tick update is a
// read then a write (save empty fetches); open only writes. Close and rejected
// requests are answered from idle. Open scans the valid bits one slot a cycle
// up to the lowest free slot (the last one when the table is full); tick walks
// the memory, reading then writing each open bucket and stepping past each
// free one. Valid bits are cleared by reset, so there is no clearing pass.
module multi_token_bucket_table #(
  parameter int BUCKETS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   kind_i,
  input  logic [mtb_pkg::SLOT_BITS-1:0] slot_i,
  input  logic [mtb_pkg::VAL_BITS-1:0] amount_i,
  input  logic [mtb_pkg::VAL_BITS-1:0] refill_rate_i,
  input  logic [mtb_pkg::VAL_BITS-1:0] burst_limit_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [mtb_pkg::SLOT_BITS-1:0] slot_out_o,
  output logic [mtb_pkg::VAL_BITS-1:0] granted_o
);
  import mtb_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WORD_W = COUNT_BITS + 2 * VAL_BITS;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);

  mtb_state_e state_q, state_d;
  logic [IDX_W-1:0]   idx_q;
  logic [BUCKETS-1:0] in_use_q;
  logic               done_q;

  // latched transaction
  logic [2:0]           kind_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic [VAL_BITS-1:0]  amount_q;
  logic [VAL_BITS-1:0]  rate_q;
  logic [VAL_BITS-1:0]  burst_q;

  // result registers
  logic [1:0]           status_q;
  logic [SLOT_BITS-1:0] slot_out_q;
  logic [VAL_BITS-1:0]  granted_q;

  // control from the output decode
  logic                 accept;
  logic                 ram_re, ram_we;
  logic [IDX_W-1:0]     ram_raddr, ram_waddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;
  logic                 idx_clr, idx_inc;
  logic                 use_set, use_clr;
  logic [IDX_W-1:0]     use_idx;
  logic                 fin;
  logic [1:0]           fin_status;
  logic [SLOT_BITS-1:0] fin_slot;
  logic [VAL_BITS-1:0]  fin_granted;

  // slot decode for the incoming and the latched transaction
  logic [IDX_W+SLOT_BITS-1:0] in_slot_wide, q_slot_wide, idx_wide;
  logic [IDX_W-1:0]           in_slot_idx, q_slot_idx;
  logic                       in_slot_ok;
  logic                       in_acc_ok;
  logic [SLOT_BITS-1:0]       idx_slot;

  assign in_slot_wide = {{IDX_W{1'b0}}, slot_i};
  assign q_slot_wide  = {{IDX_W{1'b0}}, slot_q};
  assign idx_wide     = {{SLOT_BITS{1'b0}}, idx_q};
  assign in_slot_idx  = in_slot_wide[IDX_W-1:0];
  assign q_slot_idx   = q_slot_wide[IDX_W-1:0];
  assign idx_slot     = idx_wide[SLOT_BITS-1:0];
  assign in_slot_ok   = (32'(slot_i) < BUCKETS) && in_use_q[in_slot_idx];
  assign in_acc_ok    = in_slot_ok && (amount_i != '0);

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // fields of the word read back
  logic [COUNT_BITS-1:0] rd_count;
  logic [VAL_BITS-1:0]   rd_rate, rd_burst;
  assign rd_count = ram_rdata[WORD_W-1 -: COUNT_BITS];
  assign rd_rate  = ram_rdata[2*VAL_BITS-1 -: VAL_BITS];
  assign rd_burst = ram_rdata[VAL_BITS-1:0];

  // count update
  logic                  alu_fetch, alu_empty;
  logic [VAL_BITS-1:0]   alu_addend, alu_grant;
  logic [COUNT_BITS-1:0] alu_count;

  assign alu_fetch  = (kind_q == KIND_FETCH);
  assign alu_addend = (state_q == S_ACC_WR) ? amount_q : rd_rate;

  mtb_bucket_alu #(
    .COUNT_BITS(COUNT_BITS)
  ) u_alu (
    .fetch_i (alu_fetch),
    .count_i (rd_count),
    .addend_i(alu_addend),
    .burst_i (rd_burst),
    .count_o (alu_count),
    .grant_o (alu_grant),
    .empty_o (alu_empty)
  );

  mtb_bucket_ram #(
    .DEPTH(BUCKETS),
    .WIDTH(WORD_W),
    .AW   (IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_TICK:   state_d = S_TICK_RD;
            KIND_OPEN:   state_d = S_OPEN_SCAN;
            KIND_FETCH,
            KIND_RETURN: state_d = in_acc_ok ? S_ACC_WR : S_IDLE;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_TICK_RD: begin
        if (in_use_q[idx_q]) begin
          state_d = S_TICK_WR;
        end else if (idx_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_TICK_WR: state_d = (idx_q == LAST) ? S_IDLE : S_TICK_RD;
      S_OPEN_SCAN: begin
        if (!in_use_q[idx_q] || (idx_q == LAST)) begin
          state_d = S_IDLE;
        end
      end
      S_ACC_WR: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // output decode: memory, valid bits, index and result
  always_comb begin
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {alu_count, rd_rate, rd_burst};
    idx_clr     = 1'b0;
    idx_inc     = 1'b0;
    use_set     = 1'b0;
    use_clr     = 1'b0;
    use_idx     = idx_q;
    fin         = 1'b0;
    fin_status  = STATUS_OK;
    fin_slot    = slot_q;
    fin_granted = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_TICK,
            KIND_OPEN: idx_clr = 1'b1;
            KIND_FETCH,
            KIND_RETURN: begin
              if (in_acc_ok) begin
                ram_re    = 1'b1;
                ram_raddr = in_slot_idx;
              end else begin
                fin        = 1'b1;
                fin_status = STATUS_BAD;
                fin_slot   = slot_i;
              end
            end
            KIND_CLOSE: begin
              fin      = 1'b1;
              fin_slot = slot_i;
              if (in_slot_ok) begin
                use_clr = 1'b1;
                use_idx = in_slot_idx;
              end else begin
                fin_status = STATUS_BAD;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = STATUS_BAD;
              fin_slot   = slot_i;
            end
          endcase
        end
      end
      S_TICK_RD: begin
        fin_slot = '0;
        if (in_use_q[idx_q]) begin
          ram_re = 1'b1;
        end else if (idx_q == LAST) begin
          fin = 1'b1;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_TICK_WR: begin
        fin_slot = '0;
        ram_we   = 1'b1;
        if (idx_q == LAST) begin
          fin = 1'b1;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_OPEN_SCAN: begin
        fin_slot  = '0;
        ram_wdata = {{COUNT_BITS{1'b0}}, rate_q, burst_q};
        if (!in_use_q[idx_q]) begin
          ram_we   = 1'b1;
          use_set  = 1'b1;
          fin      = 1'b1;
          fin_slot = idx_slot;
        end else if (idx_q == LAST) begin
          fin        = 1'b1;
          fin_status = STATUS_FULL;
        end else begin
          idx_inc = 1'b1;
        end
      end
      S_ACC_WR: begin
        fin       = 1'b1;
        ram_waddr = q_slot_idx;
        if (alu_fetch && alu_empty) begin
          fin_status = STATUS_EMPTY;
        end else begin
          ram_we = 1'b1;
          if (alu_fetch) begin
            fin_granted = alu_grant;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      in_use_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (idx_clr) begin
        idx_q <= '0;
      end else if (idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (use_set) begin
        in_use_q[use_idx] <= 1'b1;
      end
      if (use_clr) begin
        in_use_q[use_idx] <= 1'b0;
      end
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      slot_q   <= slot_i;
      amount_q <= amount_i;
      rate_q   <= refill_rate_i;
      burst_q  <= burst_limit_i;
    end
    if (fin) begin
      status_q   <= fin_status;
      slot_out_q <= fin_slot;
      granted_q  <= fin_granted;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign slot_out_o = slot_out_q;
  assign granted_o  = granted_q;

  // a result only appears once the controller is back in idle
  `ASSERT_ALWAYS(a_done_idle, clk_i, rst_ni, !done_o || !busy)
  // every accepted transaction either keeps working or answers next cycle
  `ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o)
  // table full is only reported when every slot is taken
  `ASSERT_ALWAYS(a_full_all_used, clk_i, rst_ni,
                 !(done_o && (status_o == STATUS_FULL)) || (&in_use_q))
  // tokens are granted only with an ok status
  `ASSERT_ALWAYS(a_grant_ok, clk_i, rst_ni,
                 !done_o || (granted_o == '0) || (status_o == STATUS_OK))

endmodule
